// ===== design/vog_pkg.sv =====
// Shared constants and types for the voxel occupancy grid.
// Used by every module in design/; depends on nothing else.

package vog_pkg;

	localparam int COORD_W    = 32;
	localparam int SIZE_REG_W = 7;
	localparam int CELL_OUT_W = 6;
	localparam int CFG_IDX_W  = 3;
	localparam int AXES       = 3;

	// Queue between front and back; also the front's reservation limit
	localparam int Q_DEPTH = 4;
	localparam int RESV_W  = $clog2(Q_DEPTH + 1);

	localparam logic [COORD_W-1:0]    COORD_MAX   = 32'h7FFF_FFFF;
	localparam logic [SIZE_REG_W-1:0] CELLS_RESET = 7'd64;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_INV_SIZE  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_CELLS_X   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_CELLS_Y   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_CELLS_Z   = 3'd7;

	// Operation codes
	localparam logic OP_MARK  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef struct packed {
		logic [AXES-1:0][COORD_W-1:0]    origin;
		logic [COORD_W-1:0]              cell_size;
		logic [COORD_W-1:0]              inv_cell_size;
		logic [AXES-1:0][SIZE_REG_W-1:0] cells;
	} cfg_t;

	typedef struct packed {
		logic clearing;
		logic taken;
	} back_status_t;

endpackage

// ===== design/vog_queue.sv =====
// Small FIFO between the front and the back of the voxel grid.
// Imports vog_pkg; the depth comes from the DEPTH parameter.

module vog_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             not_empty
);
	import vog_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] data_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CNTW-1:0]  count_q;

	assign rdata     = data_q[rd_ptr_q];
	assign not_empty = (count_q != '0);

	always_ff @(posedge clk) begin
		if (push) data_q[wr_ptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CNTW'(1);
				2'b01:   count_q <= count_q - CNTW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== design/vog_front.sv =====
// Front end of the voxel grid: input handshake, quantisation of the point
// to clamped voxel indices, and the row address. Depends on vog_pkg.

module vog_front #(
	parameter int MAX_CELLS_X   = 64,
	parameter int MAX_CELLS_Y   = 64,
	parameter int MAX_CELLS_Z   = 64,
	parameter int FRACTION_BITS = 16,
	parameter int IW            = 6,
	parameter int RW            = 12,
	parameter int EW            = 32
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  vog_pkg::cfg_t                               cfg,
	input  vog_pkg::back_status_t                       status,
	input  logic                                        in_valid,
	output logic                                        in_stall,
	input  logic                                        operation,
	input  logic [vog_pkg::AXES-1:0][vog_pkg::COORD_W-1:0] point,
	output logic                                        push,
	output logic [EW-1:0]                               entry
);
	import vog_pkg::*;

	localparam int MAX_XY  = (MAX_CELLS_X > MAX_CELLS_Y) ? MAX_CELLS_X : MAX_CELLS_Y;
	localparam int MAX_ALL = (MAX_XY > MAX_CELLS_Z) ? MAX_XY : MAX_CELLS_Z;
	localparam int SZ_W    = $clog2(MAX_ALL + 1);
	localparam int CW      = (SZ_W > SIZE_REG_W) ? SZ_W : SIZE_REG_W;
	localparam int PRODW   = 2 * COORD_W;
	localparam int QW      = PRODW - 2 * FRACTION_BITS;
	localparam int AX_MAX [AXES] = '{MAX_CELLS_X, MAX_CELLS_Y, MAX_CELLS_Z};

	function automatic logic [SZ_W-1:0] eff_size(input logic [SIZE_REG_W-1:0] r,
	                                              input int mx);
		logic [CW-1:0] w;
		w = CW'(r);
		if (w == '0) return SZ_W'(1);
		else if (w > CW'(mx)) return SZ_W'(mx);
		else return SZ_W'(w);
	endfunction

	logic              accept;
	logic [RESV_W-1:0] resv_q;

	logic valid_s1, valid_s2, valid_s3;
	logic op_s1, op_s2, op_s3;

	logic [COORD_W:0]   diff_s1 [AXES];
	logic               neg_s2  [AXES];
	logic [PRODW-1:0]   prod_s2 [AXES];
	logic [IW-1:0]      idx_s3  [AXES];
	logic               ok_s3   [AXES];

	logic [SZ_W-1:0]    size_c  [AXES];
	logic [QW-1:0]      quo_c   [AXES];
	logic [AXES-1:0][IW-1:0] idx_pk;
	logic               inside_c;
	logic [RW-1:0]      row_c;

	// Reservations cover the pipeline and the queue, so the queue never overflows
	assign in_stall = status.clearing || (resv_q == RESV_W'(Q_DEPTH));
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resv_q   <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			case ({accept, status.taken})
				2'b10:   resv_q <= resv_q + RESV_W'(1);
				2'b01:   resv_q <= resv_q - RESV_W'(1);
				default: resv_q <= resv_q;
			endcase
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			size_c[a] = eff_size(cfg.cells[a], AX_MAX[a]);
			quo_c[a]  = prod_s2[a][PRODW-1:2*FRACTION_BITS];
		end
	end

	always_ff @(posedge clk) begin
		op_s1 <= operation;
		op_s2 <= op_s1;
		op_s3 <= op_s2;
		for (int a = 0; a < AXES; a++) begin
			// 33-bit difference of sign-extended coordinates, exact
			diff_s1[a] <= {point[a][COORD_W-1], point[a]}
			            - {cfg.origin[a][COORD_W-1], cfg.origin[a]};
			neg_s2[a]  <= diff_s1[a][COORD_W];
			prod_s2[a] <= diff_s1[a][COORD_W-1:0] * cfg.inv_cell_size;
			if (neg_s2[a]) begin
				idx_s3[a] <= '0;
				ok_s3[a]  <= 1'b0;
			end else if (quo_c[a] >= QW'(size_c[a])) begin
				idx_s3[a] <= IW'(size_c[a] - SZ_W'(1));
				ok_s3[a]  <= 1'b0;
			end else begin
				idx_s3[a] <= IW'(quo_c[a]);
				ok_s3[a]  <= 1'b1;
			end
		end
	end

	always_comb begin
		for (int a = 0; a < AXES; a++) idx_pk[a] = idx_s3[a];
		inside_c = ok_s3[0] && ok_s3[1] && ok_s3[2];
		row_c    = RW'(idx_s3[0] * MAX_CELLS_Y + idx_s3[1]);
	end

	assign push  = valid_s3;
	assign entry = {op_s3, inside_c, idx_pk, row_c};

endmodule

// ===== design/vog_back.sv =====
// Back end of the voxel grid: occupancy memory with clearing pass,
// read-modify-write of a z row, centre arithmetic and result register.
// Depends on vog_pkg.

module vog_back #(
	parameter int MAX_CELLS_X = 64,
	parameter int MAX_CELLS_Y = 64,
	parameter int MAX_CELLS_Z = 64,
	parameter int IW          = 6,
	parameter int RW          = 12,
	parameter int EW          = 32
) (
	input  logic                                           clk,
	input  logic                                           arst_n,
	input  vog_pkg::cfg_t                                  cfg,
	input  logic [EW-1:0]                                  head,
	input  logic                                           head_valid,
	output vog_pkg::back_status_t                          status,
	output logic                                           out_valid,
	input  logic                                           out_stall,
	output logic                                           inside_grid,
	output logic                                           is_free,
	output logic [vog_pkg::AXES-1:0][vog_pkg::CELL_OUT_W-1:0] cell_idx,
	output logic [vog_pkg::AXES-1:0][vog_pkg::COORD_W-1:0]    center
);
	import vog_pkg::*;

	localparam int ROWS = MAX_CELLS_X * MAX_CELLS_Y;
	localparam int ZW   = (MAX_CELLS_Z > 1) ? $clog2(MAX_CELLS_Z) : 1;
	localparam int PW   = IW + COORD_W + 1;
	localparam int SW   = IW + COORD_W + 2;

	typedef enum logic [2:0] {
		BK_CLEAR  = 3'b001,
		BK_IDLE   = 3'b010,
		BK_ACCESS = 3'b100
	} back_state_t;

	back_state_t state_q;

	logic [MAX_CELLS_Z-1:0] mem [ROWS];
	logic [RW-1:0]          clr_q;

	logic                    h_op, h_inside;
	logic [AXES-1:0][IW-1:0] h_idx;
	logic [RW-1:0]           h_row;

	logic                    w_op_q, w_inside_q;
	logic [AXES-1:0][IW-1:0] w_idx_q;
	logic [RW-1:0]           w_row_q;
	logic [MAX_CELLS_Z-1:0]  rdata_q;
	logic [PW-1:0]           prod_q [AXES];

	logic                    take, load, do_mark;
	logic [ZW-1:0]           zbit;
	logic [MAX_CELLS_Z-1:0]  set_row;
	logic [SW-1:0]           sum_c    [AXES];
	logic [COORD_W-1:0]      center_c [AXES];

	assign {h_op, h_inside, h_idx, h_row} = head;

	assign take    = (state_q == BK_IDLE) && head_valid;
	assign load    = (state_q == BK_ACCESS) && (!out_valid || !out_stall);
	assign do_mark = load && (w_op_q == OP_MARK) && w_inside_q;
	assign zbit    = w_idx_q[2][ZW-1:0];

	assign status.clearing = (state_q == BK_CLEAR);
	assign status.taken    = take;

	always_comb begin
		set_row       = rdata_q;
		set_row[zbit] = 1'b1;
	end

	// Centre = origin + ((2*idx + 1) * cell_size >> 1); only the upper bound can be hit
	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			sum_c[a] = {{(SW-COORD_W){cfg.origin[a][COORD_W-1]}}, cfg.origin[a]}
			         + {2'b00, prod_q[a][PW-1:1]};
			if (!sum_c[a][SW-1] && (|sum_c[a][SW-2:COORD_W-1]))
				center_c[a] = COORD_MAX;
			else
				center_c[a] = sum_c[a][COORD_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == BK_CLEAR) mem[clr_q] <= '0;
		else if (do_mark) mem[w_row_q] <= set_row;
		if (take) rdata_q <= mem[h_row];
	end

	always_ff @(posedge clk) begin
		if (take) begin
			w_op_q     <= h_op;
			w_inside_q <= h_inside;
			w_idx_q    <= h_idx;
			w_row_q    <= h_row;
			for (int a = 0; a < AXES; a++) prod_q[a] <= {h_idx[a], 1'b1} * cfg.cell_size;
		end
		if (load) begin
			inside_grid <= w_inside_q;
			is_free     <= (w_op_q == OP_QUERY) && !rdata_q[zbit];
			for (int a = 0; a < AXES; a++) begin
				cell_idx[a] <= CELL_OUT_W'(w_idx_q[a]);
				center[a]   <= center_c[a];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_CLEAR;
			clr_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			unique case (state_q)
				BK_CLEAR: begin
					clr_q <= clr_q + RW'(1);
					if (clr_q == RW'(ROWS - 1)) state_q <= BK_IDLE;
				end
				BK_IDLE: begin
					if (take) state_q <= BK_ACCESS;
				end
				BK_ACCESS: begin
					if (load) state_q <= BK_IDLE;
				end
				default: state_q <= BK_CLEAR;
			endcase
			if (load) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
		end
	end

endmodule

// ===== design/voxel_occupancy_grid.sv =====
// Top level of the voxel occupancy grid: configuration registers, front end,
// queue and back end. Depends on vog_pkg, vog_front, vog_queue and vog_back.

// Each item is a Q16.16 point plus an operation (mark or query) and yields one
// result. The front end quantises the point in registered difference, product
// and clamp stages and parks it in a four-entry queue; the back end then takes
// the item with a row read, followed by the row write-back and result load, and
// takes no new item until that load. The occupancy memory holds one row of
// MAX_CELLS_Z bits per (x, y) pair; after reset it is swept clear one row a
// cycle, and in_stall stays high until the sweep is done. Configuration writes
// are taken at any time but must only be made while the block is idle.

module voxel_occupancy_grid #(
	parameter int MAX_CELLS_X   = 64,
	parameter int MAX_CELLS_Y   = 64,
	parameter int MAX_CELLS_Z   = 64,
	parameter int FRACTION_BITS = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_write,
	input  logic [vog_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [vog_pkg::COORD_W-1:0]            cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic                                   operation,
	input  logic signed [vog_pkg::COORD_W-1:0]     point_x,
	input  logic signed [vog_pkg::COORD_W-1:0]     point_y,
	input  logic signed [vog_pkg::COORD_W-1:0]     point_z,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic                                   inside_grid,
	output logic                                   is_free,
	output logic [vog_pkg::CELL_OUT_W-1:0]         cell_x,
	output logic [vog_pkg::CELL_OUT_W-1:0]         cell_y,
	output logic [vog_pkg::CELL_OUT_W-1:0]         cell_z,
	output logic signed [vog_pkg::COORD_W-1:0]     center_x,
	output logic signed [vog_pkg::COORD_W-1:0]     center_y,
	output logic signed [vog_pkg::COORD_W-1:0]     center_z
);
	import vog_pkg::*;

	localparam int MAX_XY  = (MAX_CELLS_X > MAX_CELLS_Y) ? MAX_CELLS_X : MAX_CELLS_Y;
	localparam int MAX_ALL = (MAX_XY > MAX_CELLS_Z) ? MAX_XY : MAX_CELLS_Z;
	localparam int IW      = (MAX_ALL > 1) ? $clog2(MAX_ALL) : 1;
	localparam int ROWS    = MAX_CELLS_X * MAX_CELLS_Y;
	localparam int RW      = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int EW      = 2 + AXES * IW + RW;
	localparam logic [COORD_W-1:0] ONE_Q = COORD_W'(64'd1 << FRACTION_BITS);

	cfg_t                             cfg_q;
	back_status_t                     status;
	logic [AXES-1:0][COORD_W-1:0]     point;
	logic                             push, head_valid;
	logic [EW-1:0]                    entry, head;
	logic [AXES-1:0][CELL_OUT_W-1:0]  cell_idx;
	logic [AXES-1:0][COORD_W-1:0]     center;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin        <= '0;
			cfg_q.cell_size     <= ONE_Q;
			cfg_q.inv_cell_size <= ONE_Q;
			cfg_q.cells         <= {AXES{CELLS_RESET}};
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_ORIGIN_X:  cfg_q.origin[0]     <= cfg_data;
				CFG_ORIGIN_Y:  cfg_q.origin[1]     <= cfg_data;
				CFG_ORIGIN_Z:  cfg_q.origin[2]     <= cfg_data;
				CFG_CELL_SIZE: cfg_q.cell_size     <= cfg_data;
				CFG_INV_SIZE:  cfg_q.inv_cell_size <= cfg_data;
				CFG_CELLS_X:   cfg_q.cells[0]      <= cfg_data[SIZE_REG_W-1:0];
				CFG_CELLS_Y:   cfg_q.cells[1]      <= cfg_data[SIZE_REG_W-1:0];
				CFG_CELLS_Z:   cfg_q.cells[2]      <= cfg_data[SIZE_REG_W-1:0];
				default:       cfg_q               <= cfg_q;
			endcase
		end
	end

	assign point = {point_z, point_y, point_x};

	vog_front #(
		.MAX_CELLS_X   (MAX_CELLS_X),
		.MAX_CELLS_Y   (MAX_CELLS_Y),
		.MAX_CELLS_Z   (MAX_CELLS_Z),
		.FRACTION_BITS (FRACTION_BITS),
		.IW            (IW),
		.RW            (RW),
		.EW            (EW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.status    (status),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.operation (operation),
		.point     (point),
		.push      (push),
		.entry     (entry)
	);

	vog_queue #(
		.WIDTH (EW),
		.DEPTH (Q_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wdata     (entry),
		.pop       (status.taken),
		.rdata     (head),
		.not_empty (head_valid)
	);

	vog_back #(
		.MAX_CELLS_X (MAX_CELLS_X),
		.MAX_CELLS_Y (MAX_CELLS_Y),
		.MAX_CELLS_Z (MAX_CELLS_Z),
		.IW          (IW),
		.RW          (RW),
		.EW          (EW)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.head        (head),
		.head_valid  (head_valid),
		.status      (status),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.inside_grid (inside_grid),
		.is_free     (is_free),
		.cell_idx    (cell_idx),
		.center      (center)
	);

	assign cell_x   = cell_idx[0];
	assign cell_y   = cell_idx[1];
	assign cell_z   = cell_idx[2];
	assign center_x = center[0];
	assign center_y = center[1];
	assign center_z = center[2];

endmodule

// ===== design/vog_checker.sv =====
// Port-level checks for the voxel occupancy grid, bound to the top level.
// Depends on vog_pkg and voxel_occupancy_grid.

module vog_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_stall,
	input logic                               out_valid,
	input logic                               out_stall,
	input logic                               inside_grid,
	input logic                               is_free,
	input logic [vog_pkg::CELL_OUT_W-1:0]     cell_x,
	input logic [vog_pkg::CELL_OUT_W-1:0]     cell_y,
	input logic [vog_pkg::CELL_OUT_W-1:0]     cell_z,
	input logic [vog_pkg::COORD_W-1:0]        center_x,
	input logic [vog_pkg::COORD_W-1:0]        center_y,
	input logic [vog_pkg::COORD_W-1:0]        center_z
);
	import vog_pkg::*;

	// Queue reservations, plus the item in the back end and the result register
	localparam int MAX_PENDING = Q_DEPTH + 2;
	localparam int PEND_W      = $clog2(MAX_PENDING + 2);

	logic              in_acc, out_acc;
	logic [PEND_W-1:0] pend_q;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			case ({in_acc, out_acc})
				2'b10:   pend_q <= pend_q + PEND_W'(1);
				2'b01:   pend_q <= pend_q - PEND_W'(1);
				default: pend_q <= pend_q;
			endcase
		end
	end

	ap_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable({inside_grid, is_free,
			cell_x, cell_y, cell_z, center_x, center_y, center_z}))
		else $error("stalled result changed or dropped");

	ap_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> pend_q != '0)
		else $error("result delivered with no item outstanding");

	ap_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> pend_q < PEND_W'(MAX_PENDING))
		else $error("more items taken than the block can hold");

	ap_clear_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> in_stall)
		else $error("items accepted during the clearing pass");

endmodule

bind voxel_occupancy_grid vog_checker u_vog_checker (.*);
